// File: hw/rtl/btsd_pkg.sv
`default_nettype none

package btsd_pkg;

    // Decoder phases.
    typedef enum logic [3:0] {
        PH_TOK_LO,
        PH_TOK_HI,
        PH_TEXT_LEN,
        PH_TEXT,
        PH_INT,
        PH_GUID,
        PH_LIST_COUNT,
        PH_LIST_ELEM
    } phase_t;

    // Result kinds.
    localparam logic [4:0] K_END        = 5'd0;
    localparam logic [4:0] K_TEXT       = 5'd3;
    localparam logic [4:0] K_INT        = 5'd4;
    localparam logic [4:0] K_FLOAT      = 5'd5;
    localparam logic [4:0] K_OPEN_ANGLE = 5'd12;
    localparam logic [4:0] K_KEYWORD    = 5'd17;
    localparam logic [4:0] K_ERROR      = 5'd18;

    // Error codes.
    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_UNKNOWN     = 3'd1;
    localparam logic [2:0] E_ENDS_INSIDE = 3'd2;
    localparam logic [2:0] E_TEXT_LONG   = 3'd3;
    localparam logic [2:0] E_LIST_LONG   = 3'd4;

    // Token codes.
    localparam logic [15:0] TC_NAME       = 16'd1;
    localparam logic [15:0] TC_STRING     = 16'd2;
    localparam logic [15:0] TC_INTEGER    = 16'd3;
    localparam logic [15:0] TC_GUID       = 16'd5;
    localparam logic [15:0] TC_INT_LIST   = 16'd6;
    localparam logic [15:0] TC_FLOAT_LIST = 16'd7;
    localparam logic [15:0] TC_PUNCT_LO   = 16'd10;
    localparam logic [15:0] TC_PUNCT_HI   = 16'd20;
    localparam logic [15:0] TC_KEYWORD    = 16'd31;
    localparam logic [15:0] TC_KW_LO      = 16'd40;
    localparam logic [15:0] TC_KW_HI      = 16'd51;
    localparam logic [4:0]  PUNCT_OFFSET  = 5'd4;

    localparam int unsigned  LEN_W      = 24;
    localparam logic [LEN_W-1:0] GUID_BYTES = 24'd16;
    localparam logic [LEN_W-1:0] LIMIT_RESET = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic CFG_MAX_TEXT = 1'b0;
    localparam logic CFG_MAX_LIST = 1'b1;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  tbyte;
        logic        tlast;
        logic [2:0]  err;
        logic        run_last;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/binary_token_stream_decoder_core.sv
// Binary token stream decoder.
// Input stream (s_*): one byte of the token stream per transfer in s_tdata,
// s_tlast high on the file's final byte. Output stream (m_*): one result per
// transfer; m_tuser is the result kind, m_tdata carries value, text byte,
// text-last flag and error code, m_tlast marks the last result of one byte.
// A byte causes zero, one or two results.
// Configuration (cfg_*): index 0 sets the longest name or string, index 1 the
// largest list count; cfg_ready is always high. Write only while idle.
// Each byte is decoded in the cycle of its transfer against the state
// registers, and its results are written into a four-entry output queue
// that drives m_*. One byte is taken per cycle while the queue holds two or
// fewer results; a byte that gives two results needs two output transfers,
// which sets the sustained rate.
// When the receiver stalls, the queue fills and s_tready drops.
// Reset empties the queue, clears the sticky error and restores both limits
// to their maximum. After an error result no more results appear until reset.
`default_nettype none

module binary_token_stream_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] token_value, [39:32] text_byte,
                                        // [40] text_last, [43:41] error_code, rest 0
    output logic [4:0]       m_tuser,   // [4:0] token_kind
    output logic             m_tlast,   // run_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data
);
    import btsd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         token_low_reg, token_low_next;
    logic [23:0]        word_reg, word_next;
    logic [1:0]         biw_reg, biw_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic               list_float_reg, list_float_next;
    logic               failed_reg, failed_next;
    logic [LEN_W-1:0]   max_text_reg, max_list_reg;

    result_t            queue_mem [4];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         count_reg;

    logic               take;
    logic               pop;
    logic [31:0]        word_full;
    logic               word_done;
    logic [15:0]        code;
    logic               too_long;
    logic               first_vld, fin_vld;
    result_t            first_res, fin_res, res_a, res_b;
    logic [1:0]         n_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= 3'd2);
    assign take      = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    assign word_full = {s_tdata, word_reg};
    assign word_done = (biw_reg == 2'd3);
    assign code      = {s_tdata, token_low_reg};
    assign too_long  = (word_full[31:24] != 8'd0);

    always_comb
    begin
        phase_next      = phase_reg;
        token_low_next  = token_low_reg;
        word_next       = word_reg;
        biw_next        = biw_reg;
        left_next       = left_reg;
        list_float_next = list_float_reg;
        failed_next     = failed_reg;
        first_vld       = 1'b0;
        first_res       = '0;
        fin_vld         = 1'b0;
        fin_res         = '0;

        if (take && !failed_reg)
        begin
            // Little-endian word assembly for the phases that collect 32 bits.
            if (phase_reg == PH_TEXT_LEN || phase_reg == PH_INT ||
                phase_reg == PH_LIST_COUNT || phase_reg == PH_LIST_ELEM)
            begin
                biw_next = biw_reg + 2'd1;
                unique case (biw_reg)
                    2'd0:    word_next = {16'd0, s_tdata};
                    2'd1:    word_next[15:8] = s_tdata;
                    2'd2:    word_next[23:16] = s_tdata;
                    default: word_next = word_reg;
                endcase
            end

            unique case (phase_reg)
                PH_TOK_LO:
                begin
                    if (!s_tlast)
                    begin
                        token_low_next = s_tdata;
                        phase_next     = PH_TOK_HI;
                    end
                end
                PH_TOK_HI:
                begin
                    phase_next = PH_TOK_LO;
                    biw_next   = 2'd0;
                    if (code == TC_NAME || code == TC_STRING)
                        phase_next = PH_TEXT_LEN;
                    else if (code == TC_INTEGER)
                        phase_next = PH_INT;
                    else if (code == TC_GUID)
                    begin
                        phase_next = PH_GUID;
                        left_next  = GUID_BYTES;
                    end
                    else if (code == TC_INT_LIST || code == TC_FLOAT_LIST)
                    begin
                        phase_next      = PH_LIST_COUNT;
                        list_float_next = (code == TC_FLOAT_LIST);
                    end
                    else if (code >= TC_PUNCT_LO && code <= TC_PUNCT_HI)
                    begin
                        first_vld      = 1'b1;
                        first_res.kind = code[4:0] - PUNCT_OFFSET;
                    end
                    else if (code == TC_KEYWORD || (code >= TC_KW_LO && code <= TC_KW_HI))
                    begin
                        first_vld      = 1'b1;
                        first_res.kind = K_KEYWORD;
                    end
                    else
                    begin
                        first_vld      = 1'b1;
                        first_res.kind = K_ERROR;
                        first_res.err  = E_UNKNOWN;
                        failed_next    = 1'b1;
                    end
                end
                PH_TEXT_LEN:
                begin
                    if (word_done)
                    begin
                        first_vld = 1'b1;
                        if (too_long || word_full[23:0] > max_text_reg)
                        begin
                            first_res.kind = K_ERROR;
                            first_res.err  = E_TEXT_LONG;
                            failed_next    = 1'b1;
                        end
                        else
                        begin
                            first_res.kind  = {3'd0, token_low_reg[1:0]};
                            first_res.value = word_full;
                            left_next       = word_full[23:0];
                            phase_next      = (word_full == 32'd0) ? PH_TOK_LO : PH_TEXT;
                        end
                    end
                end
                PH_TEXT:
                begin
                    left_next       = left_reg - 24'd1;
                    first_vld       = 1'b1;
                    first_res.kind  = K_TEXT;
                    first_res.tbyte = s_tdata;
                    first_res.tlast = (left_reg == 24'd1);
                    if (left_reg == 24'd1)
                        phase_next = PH_TOK_LO;
                end
                PH_INT:
                begin
                    if (word_done)
                    begin
                        first_vld       = 1'b1;
                        first_res.kind  = K_INT;
                        first_res.value = word_full;
                        phase_next      = PH_TOK_LO;
                    end
                end
                PH_GUID:
                begin
                    left_next = left_reg - 24'd1;
                    if (left_reg == 24'd1)
                    begin
                        first_vld      = 1'b1;
                        first_res.kind = K_OPEN_ANGLE;
                        phase_next     = PH_TOK_LO;
                    end
                end
                PH_LIST_COUNT:
                begin
                    if (word_done)
                    begin
                        if (too_long || word_full[23:0] > max_list_reg)
                        begin
                            first_vld      = 1'b1;
                            first_res.kind = K_ERROR;
                            first_res.err  = E_LIST_LONG;
                            failed_next    = 1'b1;
                        end
                        else
                        begin
                            left_next  = word_full[23:0];
                            phase_next = (word_full == 32'd0) ? PH_TOK_LO : PH_LIST_ELEM;
                        end
                    end
                end
                PH_LIST_ELEM:
                begin
                    if (word_done)
                    begin
                        first_vld       = 1'b1;
                        first_res.kind  = list_float_reg ? K_FLOAT : K_INT;
                        first_res.value = word_full;
                        left_next       = left_reg - 24'd1;
                        if (left_reg == 24'd1)
                            phase_next = PH_TOK_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_TOK_LO;
                end
            endcase

            // The final byte closes the file: end if between tokens, else an error.
            if (s_tlast && !failed_next)
            begin
                fin_vld = 1'b1;
                if (phase_next == PH_TOK_LO)
                    fin_res.kind = K_END;
                else
                begin
                    fin_res.kind = K_ERROR;
                    fin_res.err  = E_ENDS_INSIDE;
                    failed_next  = 1'b1;
                end
            end
        end

        first_res.run_last = !fin_vld;
        fin_res.run_last   = 1'b1;
        res_a = first_vld ? first_res : fin_res;
        res_b = fin_res;
        n_res = {1'b0, first_vld} + {1'b0, fin_vld};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TOK_LO;
            token_low_reg  <= '0;
            word_reg       <= '0;
            biw_reg        <= '0;
            left_reg       <= '0;
            list_float_reg <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            token_low_reg  <= token_low_next;
            word_reg       <= word_next;
            biw_reg        <= biw_next;
            left_reg       <= left_next;
            list_float_reg <= list_float_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_text_reg <= LIMIT_RESET;
            max_list_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_TEXT: max_text_reg <= cfg_data;
                CFG_MAX_LIST: max_list_reg <= cfg_data;
                default:      max_text_reg <= max_text_reg;
            endcase
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            queue_mem[wr_ptr_reg] <= res_a;
        if (n_res == 2'd2)
            queue_mem[wr_ptr_reg + 2'd1] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_res;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, n_res} - {2'b00, pop};
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tuser  = queue_mem[rd_ptr_reg].kind;
    assign m_tlast  = queue_mem[rd_ptr_reg].run_last;
    assign m_tdata  = {4'd0, queue_mem[rd_ptr_reg].err, queue_mem[rd_ptr_reg].tlast,
                       queue_mem[rd_ptr_reg].tbyte, queue_mem[rd_ptr_reg].value};

endmodule

`default_nettype wire
